/* rtl/dsei_pkg.sv */
package dsei_pkg;

	localparam int TABLE_CAPACITY = 1024;
	localparam int NODE_ID_BITS   = 24;

	localparam int POS_W    = 32;
	localparam int TIME_W   = 32;
	localparam int NODE_W   = 24;
	localparam int RANK_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;

	localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT     = 2'd0,
		ACT_READ_START = 2'd1,
		ACT_READ_END   = 2'd2,
		ACT_CLEAR      = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_BAD_RANK = 2'd2
	} status_t;

	// Negate the parent time; the most negative value saturates.
	function automatic logic signed [TIME_W-1:0] sat_neg(input logic signed [TIME_W-1:0] t);
		logic signed [TIME_W-1:0] r;
		if (t == TIME_MIN) begin
			r = TIME_MAX;
		end else begin
			r = -t;
		end
		return r;
	endfunction

endpackage

/* rtl/dsei_cell.sv */
module dsei_cell #(
	parameter int W = 112
) (
	input  logic         clk,
	input  logic         ins_en,
	input  logic [W-1:0] new_data,
	input  logic         valid,
	input  logic         prev_valid,
	input  logic         prev_gt,
	input  logic [W-1:0] prev_data,
	output logic         gt,
	output logic [W-1:0] data_q
);
	import dsei_pkg::*;

	logic [POS_W-1:0]         my_pos;
	logic [POS_W-1:0]         nw_pos;
	logic signed [TIME_W-1:0] my_key;
	logic signed [TIME_W-1:0] nw_key;

	assign my_pos = data_q[W-1 -: POS_W];
	assign nw_pos = new_data[W-1 -: POS_W];
	assign my_key = data_q[W-POS_W-1 -: TIME_W];
	assign nw_key = new_data[W-POS_W-1 -: TIME_W];

	// Entry sorts strictly after the new edge: equal keys stay ahead of it.
	assign gt = valid && ((my_pos > nw_pos) || ((my_pos == nw_pos) && (my_key > nw_key)));

	always_ff @(posedge clk) begin
		if (ins_en) begin
			priority if (prev_gt) begin
				data_q <= prev_data;
			end else if (gt || (!valid && prev_valid)) begin
				data_q <= new_data;
			end else begin
				data_q <= data_q;
			end
		end
	end

endmodule

/* rtl/dsei_chain.sv */
module dsei_chain #(
	parameter int N  = 1024,
	parameter int W  = 112,
	parameter int CW = 11
) (
	input  logic          clk,
	input  logic          ins_en,
	input  logic [W-1:0]  new_data,
	input  logic [CW-1:0] count,
	output logic [W-1:0]  data [N]
);
	import dsei_pkg::*;

	logic [N-1:0] valid;
	logic [N-1:0] gt;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic         p_valid;
		logic         p_gt;
		logic [W-1:0] p_data;

		assign valid[i] = (CW'(i) < count);

		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_gt    = 1'b0;
			assign p_data  = '0;
		end else begin : g_body
			assign p_valid = valid[i-1];
			assign p_gt    = gt[i-1];
			assign p_data  = data[i-1];
		end

		dsei_cell #(.W(W)) u_cell (
			.clk        (clk),
			.ins_en     (ins_en),
			.new_data   (new_data),
			.valid      (valid[i]),
			.prev_valid (p_valid),
			.prev_gt    (p_gt),
			.prev_data  (p_data),
			.gt         (gt[i]),
			.data_q     (data[i])
		);
	end

endmodule

/* rtl/dsei_rdtree.sv */
module dsei_rdtree #(
	parameter int N = 1024,
	parameter int W = 112
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);
	import dsei_pkg::*;

	localparam int P = 1 << $clog2(N);

	logic [W-1:0] lf     [P];
	logic [W-1:0] tree_q [1:P-1];

	for (genvar j = 0; j < P; j++) begin : g_pad
		if (j < N) begin : g_used
			assign lf[j] = leaf[j];
		end else begin : g_zero
			assign lf[j] = '0;
		end
	end

	// Heap order: node k merges nodes 2k and 2k+1, one level per cycle.
	for (genvar k = 1; k < P; k++) begin : g_node
		if (2 * k >= P) begin : g_low
			always_ff @(posedge clk) begin
				tree_q[k] <= lf[2*k-P] | lf[2*k+1-P];
			end
		end else begin : g_high
			always_ff @(posedge clk) begin
				tree_q[k] <= tree_q[2*k] | tree_q[2*k+1];
			end
		end
	end

	assign root = tree_q[1];

endmodule

/* rtl/dual_sorted_edge_index_top.sv */
// Two sorted edge tables built as insertion chains of cells, one cell per entry. For insert
// and clear commands busy stays low and a new command may start every cycle, with its result
// strobed on done in the next cycle. A read keeps busy high while the selected entry climbs a
// registered OR tree over all cells, one level per cycle; its result is strobed on done in the
// same cycle that busy falls. Every result appears on done for exactly one cycle and cannot be
// held off; capture it then.
module dual_sorted_edge_index_top #(
	parameter int TABLE_CAPACITY = dsei_pkg::TABLE_CAPACITY,
	parameter int NODE_ID_BITS   = dsei_pkg::NODE_ID_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [dsei_pkg::ACTION_W-1:0]        action,
	input  logic [dsei_pkg::POS_W-1:0]           left_pos,
	input  logic [dsei_pkg::POS_W-1:0]           right_pos,
	input  logic [dsei_pkg::NODE_W-1:0]          parent_node,
	input  logic [dsei_pkg::NODE_W-1:0]          child_node,
	input  logic signed [dsei_pkg::TIME_W-1:0]   parent_time,
	input  logic [dsei_pkg::RANK_W-1:0]          read_rank,
	output logic                                 done,
	output logic [dsei_pkg::POS_W-1:0]           entry_pos,
	output logic signed [dsei_pkg::TIME_W-1:0]   entry_time,
	output logic [dsei_pkg::NODE_W-1:0]          entry_parent,
	output logic [dsei_pkg::NODE_W-1:0]          entry_child,
	output logic [dsei_pkg::COUNT_W-1:0]         stored_count,
	output logic [dsei_pkg::STATUS_W-1:0]        status
);
	import dsei_pkg::*;

	localparam int NB  = NODE_ID_BITS;
	localparam int W   = POS_W + TIME_W + 2 * NB;
	localparam int CW  = $clog2(TABLE_CAPACITY + 1);
	localparam int IW  = $clog2(TABLE_CAPACITY);
	localparam int RW  = (CW > RANK_W) ? CW : RANK_W;
	localparam int LAST = IW;
	localparam int WCW = $clog2(LAST + 1);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	action_t           act_q;
	logic [RANK_W-1:0] rank_q;
	logic [WCW-1:0]    wait_q;

	action_t      act_in;
	logic         accept;
	logic         full;
	logic         ins_en;
	logic [W-1:0] start_new;
	logic [W-1:0] end_new;
	logic [W-1:0] start_data [TABLE_CAPACITY];
	logic [W-1:0] end_data   [TABLE_CAPACITY];
	logic [W-1:0] leaf       [TABLE_CAPACITY];
	logic [W-1:0] root;
	logic         rank_ok;

	assign act_in = action_t'(action);
	assign busy   = (state_q == ST_READ);
	assign accept = start && !busy;
	assign full   = (count_q == CW'(TABLE_CAPACITY));
	assign ins_en = accept && (act_in == ACT_INSERT) && !full;

	assign start_new = {left_pos, sat_neg(parent_time), NB'(parent_node), NB'(child_node)};
	assign end_new   = {right_pos, parent_time, NB'(parent_node), NB'(child_node)};

	dsei_chain #(.N(TABLE_CAPACITY), .W(W), .CW(CW)) u_start_chain (
		.clk      (clk),
		.ins_en   (ins_en),
		.new_data (start_new),
		.count    (count_q),
		.data     (start_data)
	);

	dsei_chain #(.N(TABLE_CAPACITY), .W(W), .CW(CW)) u_end_chain (
		.clk      (clk),
		.ins_en   (ins_en),
		.new_data (end_new),
		.count    (count_q),
		.data     (end_data)
	);

	// Only the addressed cell drives its entry into the tree.
	for (genvar i = 0; i < TABLE_CAPACITY; i++) begin : g_leaf
		assign leaf[i] = (RW'(i) == RW'(rank_q))
			? ((act_q == ACT_READ_START) ? start_data[i] : end_data[i]) : '0;
	end

	dsei_rdtree #(.N(TABLE_CAPACITY), .W(W)) u_rdtree (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	assign rank_ok = (RW'(rank_q) < RW'(count_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			done         <= 1'b0;
			act_q        <= ACT_READ_START;
			rank_q       <= '0;
			wait_q       <= '0;
			entry_pos    <= '0;
			entry_time   <= '0;
			entry_parent <= '0;
			entry_child  <= '0;
			stored_count <= '0;
			status       <= STAT_OK;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						entry_pos    <= '0;
						entry_time   <= '0;
						entry_parent <= '0;
						entry_child  <= '0;
						status       <= STAT_OK;
						unique case (act_in)
							ACT_INSERT: begin
								done <= 1'b1;
								if (full) begin
									status       <= STAT_FULL;
									stored_count <= COUNT_W'(count_q);
								end else begin
									count_q      <= count_q + 1'b1;
									stored_count <= COUNT_W'(count_q + 1'b1);
								end
							end
							ACT_CLEAR: begin
								done         <= 1'b1;
								count_q      <= '0;
								stored_count <= '0;
							end
							ACT_READ_START, ACT_READ_END: begin
								act_q   <= act_in;
								rank_q  <= read_rank;
								wait_q  <= '0;
								state_q <= ST_READ;
							end
						endcase
					end
				end
				ST_READ: begin
					if (wait_q == WCW'(LAST)) begin
						done         <= 1'b1;
						state_q      <= ST_IDLE;
						stored_count <= COUNT_W'(count_q);
						if (rank_ok) begin
							status       <= STAT_OK;
							entry_pos    <= root[W-1 -: POS_W];
							entry_time   <= root[W-POS_W-1 -: TIME_W];
							entry_parent <= NODE_W'(root[2*NB-1 -: NB]);
							entry_child  <= NODE_W'(root[NB-1:0]);
						end else begin
							status       <= STAT_BAD_RANK;
							entry_pos    <= '0;
							entry_time   <= '0;
							entry_parent <= '0;
							entry_child  <= '0;
						end
					end else begin
						wait_q <= wait_q + 1'b1;
					end
				end
			endcase
		end
	end

endmodule

/* rtl/dsei_checker.sv */
module dsei_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [dsei_pkg::ACTION_W-1:0]       action,
	input logic                                done,
	input logic [dsei_pkg::POS_W-1:0]          entry_pos,
	input logic [dsei_pkg::NODE_W-1:0]         entry_parent,
	input logic [dsei_pkg::COUNT_W-1:0]        stored_count,
	input logic [dsei_pkg::STATUS_W-1:0]       status
);
	import dsei_pkg::*;

	// Insert and clear finish in the next cycle.
	a_short_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_INSERT || action == ACT_CLEAR)) |=> done)
		else $error("insert or clear beat gave no result next cycle");

	// A read holds the block busy.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_READ_START || action == ACT_READ_END)) |=> busy)
		else $error("read beat did not raise busy");

	// Clear empties both tables.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_CLEAR) |=>
			(stored_count == '0 && status == STAT_OK))
		else $error("clear result wrong");

	// A rejected read shows no entry.
	a_bad_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_BAD_RANK) |-> (entry_pos == '0 && entry_parent == '0))
		else $error("bad rank result carries entry data");

	// Between back-to-back OK results, a nonzero count moves by at most one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && status == STAT_OK && $past(status) == STAT_OK
			&& stored_count != '0) |->
			(stored_count == $past(stored_count) || stored_count == $past(stored_count) + 1'b1))
		else $error("stored count jumped");

endmodule

bind dual_sorted_edge_index_top dsei_checker u_dsei_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.action       (action),
	.done         (done),
	.entry_pos    (entry_pos),
	.entry_parent (entry_parent),
	.stored_count (stored_count),
	.status       (status)
);
